[design/assd_pkg.sv]
// ----------------------------------------------------------------------------
// assd_pkg
// Shared constants and types for the audio slot select decimator.
// ----------------------------------------------------------------------------
package assd_pkg;

    localparam int MAX_DETECT = 64;
    localparam int MAX_BLOCK  = 4096;

    localparam int SAMPLE_W = 16;
    localparam int WORD_W   = 32;
    localparam int BLK_W    = 13;
    localparam int DET_W    = 7;
    localparam int POS_W    = 12;
    localparam int ADDR_W   = $clog2(MAX_DETECT);
    localparam int SUM_W    = 21;
    localparam int CFG_W    = 13;
    localparam int CFG_IX_W = 1;

    localparam logic [CFG_IX_W-1:0] REG_BLOCK_WORDS  = 1'b0;
    localparam logic [CFG_IX_W-1:0] REG_DETECT_WORDS = 1'b1;

    localparam logic [BLK_W-1:0] BLOCK_WORDS_RST  = 13'd1000;
    localparam logic [DET_W-1:0] DETECT_WORDS_RST = 7'd64;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

    // per-word decode, produced by the step logic
    typedef struct packed {
        logic [BLK_W-1:0]  blk_m1;
        logic [DET_W-1:0]  det;
        logic [ADDR_W-1:0] addr;
        logic              endb;
        logic              emit;
        logic              store;
        logic              decide;
        logic              phase_n;
        logic              decided_n;
        logic [POS_W-1:0]  pos_n;
        logic [SUM_W-1:0]  even_n;
        logic [SUM_W-1:0]  odd_n;
    } t_step;

endpackage

[design/assd_step.sv]
// ----------------------------------------------------------------------------
// assd_step
// Per-word decode: clamps the block and detection lengths, locates the word
// in its block, updates the detection sums and makes the phase decision.
// ----------------------------------------------------------------------------
module assd_step (
    input  logic [assd_pkg::BLK_W-1:0]    i_cfg_blk,
    input  logic [assd_pkg::DET_W-1:0]    i_cfg_det,
    input  logic [assd_pkg::POS_W-1:0]    i_pos,
    input  logic [assd_pkg::SUM_W-1:0]    i_even,
    input  logic [assd_pkg::SUM_W-1:0]    i_odd,
    input  logic                          i_decided,
    input  logic                          i_phase,
    input  logic [assd_pkg::SAMPLE_W-1:0] i_sample,
    output assd_pkg::t_step               o_step
);
    import assd_pkg::*;

    logic [BLK_W-1:0]    blk;
    logic [DET_W-1:0]    det_c;
    logic [DET_W-1:0]    det;
    logic                restart;
    logic [POS_W-1:0]    p;
    logic [SUM_W-1:0]    even_b;
    logic [SUM_W-1:0]    odd_b;
    logic                decided_b;
    logic                in_win;
    logic [SAMPLE_W-1:0] mag;
    logic [SUM_W-1:0]    even_u;
    logic [SUM_W-1:0]    odd_u;

    always_comb begin
        if (i_cfg_blk < BLK_W'(2)) begin
            blk = BLK_W'(2);
        end else if (i_cfg_blk > BLK_W'(MAX_BLOCK)) begin
            blk = BLK_W'(MAX_BLOCK);
        end else begin
            blk = i_cfg_blk;
        end

        if (i_cfg_det == '0) begin
            det_c = DET_W'(1);
        end else if (i_cfg_det > DET_W'(MAX_DETECT)) begin
            det_c = DET_W'(MAX_DETECT);
        end else begin
            det_c = i_cfg_det;
        end
        det = ({{(BLK_W-DET_W){1'b0}}, det_c} > blk) ? blk[DET_W-1:0] : det_c;

        restart   = {1'b0, i_pos} >= blk;
        p         = restart ? '0 : i_pos;
        even_b    = restart ? '0 : i_even;
        odd_b     = restart ? '0 : i_odd;
        decided_b = restart ? 1'b0 : i_decided;

        in_win = {1'b0, p} < {{(BLK_W-DET_W){1'b0}}, det};
        mag    = i_sample[SAMPLE_W-1] ? (SAMPLE_W'(0) - i_sample) : i_sample;

        even_u = even_b;
        odd_u  = odd_b;
        if (!decided_b && in_win) begin
            if (p[0]) begin
                odd_u = odd_b + {{(SUM_W-SAMPLE_W){1'b0}}, mag};
            end else begin
                even_u = even_b + {{(SUM_W-SAMPLE_W){1'b0}}, mag};
            end
        end

        o_step.blk_m1 = blk - BLK_W'(1);
        o_step.det    = det;
        o_step.addr   = p[ADDR_W-1:0];
        o_step.endb   = {1'b0, p} == o_step.blk_m1;
        o_step.emit   = decided_b && (p[0] == i_phase);
        o_step.store  = !decided_b && in_win;
        o_step.decide = o_step.store
                        && ({1'b0, p} == {{(BLK_W-DET_W){1'b0}}, det} - BLK_W'(1));
        o_step.phase_n   = o_step.decide ? (odd_u > even_u) : i_phase;
        o_step.decided_n = o_step.endb ? 1'b0 : (decided_b || o_step.decide);
        o_step.pos_n     = o_step.endb ? '0 : p + POS_W'(1);
        o_step.even_n    = o_step.endb ? '0 : even_u;
        o_step.odd_n     = o_step.endb ? '0 : odd_u;
    end

endmodule

[design/audio_slot_select_decimator_core.sv]
// ----------------------------------------------------------------------------
// audio_slot_select_decimator_core
// Picks the live slot (even or odd word positions) of each capture block and
// streams its 16-bit samples.
// ----------------------------------------------------------------------------
// An ordinary word gives at most one sample. The word
// that closes the detection window gives the held samples of the chosen
// phase, up to 32; they are read one per cycle, unless the output stalls, from
// the 64-entry sample RAM, and the input is held off until the last of them
// is loaded into the output register. The sample RAM has no clearing pass.
module audio_slot_select_decimator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [assd_pkg::CFG_IX_W-1:0] i_cfg_index,
    input  logic [assd_pkg::CFG_W-1:0]    i_cfg_data,
    // input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [assd_pkg::WORD_W-1:0]   i_s_axis_tdata,   // [31:0] capture_word
    // output stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic signed [assd_pkg::SAMPLE_W-1:0] o_m_axis_tdata, // [15:0] sample
    output logic                          o_m_axis_tlast,   // run_last
    output logic [1:0]                    o_m_axis_tuser    // [0] phase, [1] block_last
);
    import assd_pkg::*;

    logic [BLK_W-1:0]    r_cfg_blk;
    logic [DET_W-1:0]    r_cfg_det;

    t_state              r_state;
    t_state              n_state;
    logic [POS_W-1:0]    r_pos;
    logic [SUM_W-1:0]    r_even;
    logic [SUM_W-1:0]    r_odd;
    logic                r_decided;
    logic                r_phase;

    logic [SAMPLE_W-1:0] r_mem [MAX_DETECT];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic [DET_W-1:0]    r_rd_idx;
    logic                r_rd_pend;
    logic [DET_W-1:0]    r_issue_idx;
    logic [DET_W-1:0]    r_drain_det;
    logic [BLK_W-1:0]    r_drain_blk_m1;

    logic                r_o_valid;
    logic [SAMPLE_W-1:0] r_o_sample;
    logic                r_o_phase;
    logic                r_o_last;
    logic                r_o_blast;

    t_step               step;
    logic                out_free;
    logic                in_acc;
    logic                mem_load;
    logic                rd_issue;
    logic                drain_last;
    logic [SAMPLE_W-1:0] in_sample;

    assign in_sample = i_s_axis_tdata[WORD_W-1:WORD_W-SAMPLE_W];

    assd_step u_step (
        .i_cfg_blk (r_cfg_blk),
        .i_cfg_det (r_cfg_det),
        .i_pos     (r_pos),
        .i_even    (r_even),
        .i_odd     (r_odd),
        .i_decided (r_decided),
        .i_phase   (r_phase),
        .i_sample  (in_sample),
        .o_step    (step)
    );

    assign out_free        = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign mem_load        = r_rd_pend && out_free;
    assign rd_issue        = (r_state == S_DRAIN) && (r_issue_idx < r_drain_det)
                             && (!r_rd_pend || mem_load);
    assign drain_last      = ({1'b0, r_rd_idx} + (DET_W+1)'(2)) >= {1'b0, r_drain_det};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && step.decide) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (mem_load && drain_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_blk <= BLOCK_WORDS_RST;
            r_cfg_det <= DETECT_WORDS_RST;
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_even    <= '0;
            r_odd     <= '0;
            r_decided <= 1'b0;
            r_phase   <= 1'b0;
            r_rd_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_BLOCK_WORDS:  r_cfg_blk <= i_cfg_data;
                    REG_DETECT_WORDS: r_cfg_det <= i_cfg_data[DET_W-1:0];
                    default: ;
                endcase
            end
            r_state <= n_state;
            if (in_acc) begin
                r_pos     <= step.pos_n;
                r_even    <= step.even_n;
                r_odd     <= step.odd_n;
                r_decided <= step.decided_n;
                r_phase   <= step.phase_n;
            end
            if (rd_issue) begin
                r_rd_pend <= 1'b1;
            end else if (mem_load) begin
                r_rd_pend <= 1'b0;
            end
            if ((in_acc && step.emit) || mem_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // drain bookkeeping and output payload
    always_ff @(posedge i_clk) begin
        if (in_acc && step.decide) begin
            r_issue_idx    <= {{(DET_W-1){1'b0}}, step.phase_n};
            r_drain_det    <= step.det;
            r_drain_blk_m1 <= step.blk_m1;
        end else if (rd_issue) begin
            r_issue_idx <= r_issue_idx + DET_W'(2);
        end
        if (in_acc && step.emit) begin
            r_o_sample <= in_sample;
            r_o_phase  <= r_phase;
            r_o_last   <= 1'b1;
            r_o_blast  <= step.endb;
        end else if (mem_load) begin
            r_o_sample <= r_rd_data;
            r_o_phase  <= r_phase;
            r_o_last   <= drain_last;
            r_o_blast  <= {{(BLK_W-DET_W){1'b0}}, r_rd_idx} == r_drain_blk_m1;
        end
    end

    // held sample RAM: written in the detection window, read during drain
    always_ff @(posedge i_clk) begin
        if (in_acc && step.store) begin
            r_mem[step.addr] <= in_sample;
        end
        if (rd_issue) begin
            r_rd_data <= r_mem[r_issue_idx[ADDR_W-1:0]];
            r_rd_idx  <= r_issue_idx;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_sample;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tuser  = {r_o_blast, r_o_phase};

    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_pend && !out_free) |=> (r_rd_pend && $stable(r_rd_data)))
        else $error("held read data lost under output stall");

    a_rd_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_load |-> (r_rd_idx[0] == r_phase))
        else $error("drained sample from the wrong phase");

    a_issue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_issue |-> (r_issue_idx < DET_W'(MAX_DETECT)))
        else $error("sample RAM read beyond the detection window");

    a_decided_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_decided |-> (r_pos != '0))
        else $error("phase decided at the start of a block");

endmodule

[tb/sv/assd_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assd_stream_checker
// Scoreboard for the audio slot select decimator. Follows register writes and
// accepted capture words, predicts the PCM sample transactions they cause, and
// compares each accepted sample field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module assd_stream_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [assd_pkg::CFG_IX_W-1:0]        i_cfg_index,
    input  logic [assd_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_s_axis_tvalid,
    input  logic                                 i_s_axis_tready,
    input  logic [assd_pkg::WORD_W-1:0]          i_s_axis_tdata,   // [31:0] capture_word
    input  logic                                 i_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    input  logic signed [assd_pkg::SAMPLE_W-1:0] i_m_axis_tdata,   // [15:0] sample
    input  logic                                 i_m_axis_tlast,   // run_last
    input  logic [1:0]                           i_m_axis_tuser,   // [0] phase, [1] block_last
    output int                                   o_mismatches,
    output int                                   o_outstanding,
    output int                                   o_samples_seen
);
    import assd_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       phase;
        logic                       run_last;
        logic                       block_last;
    } t_pcm_result;

    logic [BLK_W-1:0]    block_words_q;
    logic [DET_W-1:0]    detect_words_q;
    logic [SAMPLE_W-1:0] held [MAX_DETECT];
    int unsigned         word_pos;
    logic [SUM_W-1:0]    even_sum;
    logic [SUM_W-1:0]    odd_sum;
    logic                chosen_phase;
    logic                decided;
    t_pcm_result         pending_samples[$];

    function automatic void open_block();
        word_pos = 0;
        even_sum = '0;
        odd_sum  = '0;
        decided  = 1'b0;
    endfunction

    function automatic void queue_sample(input logic [SAMPLE_W-1:0] smp,
                                         input logic last_of_block);
        t_pcm_result r;
        r.sample     = smp;
        r.phase      = chosen_phase;
        r.run_last   = 1'b0;
        r.block_last = last_of_block;
        pending_samples.push_back(r);
    endfunction

    function automatic void decimate_word(input logic [WORD_W-1:0] word);
        int unsigned         blk;
        int unsigned         det;
        int unsigned         pos;
        int unsigned         ix;
        int unsigned         queued;
        logic [SAMPLE_W-1:0] smp;
        logic [SAMPLE_W:0]   mag;
        logic                endb;
        blk = 32'(block_words_q);
        if (blk < 2) blk = 2;
        if (blk > MAX_BLOCK) blk = MAX_BLOCK;
        det = 32'(detect_words_q);
        if (det < 1) det = 1;
        if (det > MAX_DETECT) det = MAX_DETECT;
        if (det > blk) det = blk;
        smp    = word[WORD_W-1:SAMPLE_W];
        queued = pending_samples.size();

        // a shortened block restarts on the word that overruns it
        if (word_pos >= blk) open_block();
        pos  = word_pos;
        endb = (pos == blk - 1);

        if (decided) begin
            if (pos[0] == chosen_phase) queue_sample(smp, endb);
        end else if (pos < det) begin
            mag = smp[SAMPLE_W-1] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
            if (pos[0]) odd_sum += SUM_W'(mag);
            else even_sum += SUM_W'(mag);
            held[pos % MAX_DETECT] = smp;
            if (pos == det - 1) begin
                chosen_phase = (odd_sum > even_sum);
                decided      = 1'b1;
                for (ix = 32'(chosen_phase); ix < det; ix += 2)
                    queue_sample(held[ix % MAX_DETECT], ix == blk - 1);
            end
        end
        // past the window while undecided: nothing until the next block

        if (pending_samples.size() > queued)
            pending_samples[pending_samples.size() - 1].run_last = 1'b1;

        if (endb) open_block();
        else word_pos = pos + 1;
    endfunction

    function automatic void compare_field(input string field, input int want_v,
                                          input int got_v);
        if (want_v != got_v) begin
            $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pcm_result want;
        if (!i_rst_n) begin
            block_words_q  = BLOCK_WORDS_RST;
            detect_words_q = DETECT_WORDS_RST;
            chosen_phase   = 1'b0;
            open_block();
            pending_samples.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_BLOCK_WORDS:  block_words_q  = i_cfg_data[BLK_W-1:0];
                    REG_DETECT_WORDS: detect_words_q = i_cfg_data[DET_W-1:0];
                    default: ;
                endcase
            end
            // predict first so a same-cycle sample still finds its entry
            if (i_s_axis_tvalid && i_s_axis_tready) decimate_word(i_s_axis_tdata);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                o_samples_seen++;
                if (pending_samples.size() == 0) begin
                    $error("sample %0d arrived with none predicted", i_m_axis_tdata);
                    o_mismatches++;
                end else begin
                    want = pending_samples.pop_front();
                    compare_field("sample", int'(want.sample), int'(i_m_axis_tdata));
                    compare_field("phase", int'(want.phase), int'(i_m_axis_tuser[0]));
                    compare_field("run_last", int'(want.run_last), int'(i_m_axis_tlast));
                    compare_field("block_last", int'(want.block_last),
                                  int'(i_m_axis_tuser[1]));
                end
            end
        end
        o_outstanding = pending_samples.size();
    end

endmodule

[tb/sv/audio_slot_select_decimator_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_slot_select_decimator_core_tb
// Stimulus for the slot select decimator: register settings across their full
// range, directed corner blocks, then random capture words with random valid
// and ready gaps and one long output stall. A scoreboard beside the core does
// the checking; this module gives the verdict.
// ----------------------------------------------------------------------------
module audio_slot_select_decimator_core_tb;
    import assd_pkg::*;

    localparam int RANDOM_WORDS = 420;
    localparam int CALM_WORDS   = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;   // a full drain of 32 held samples plus margin
    localparam int STALL_LIMIT  = 3000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [CFG_IX_W-1:0]        i_cfg_index;
    logic [CFG_W-1:0]           i_cfg_data;
    logic                       i_s_axis_tvalid;
    logic                       o_s_axis_tready;
    logic [WORD_W-1:0]          i_s_axis_tdata;
    logic                       o_m_axis_tvalid;
    logic                       i_m_axis_tready;
    logic signed [SAMPLE_W-1:0] o_m_axis_tdata;
    logic                       o_m_axis_tlast;
    logic [1:0]                 o_m_axis_tuser;

    int mismatches;
    int outstanding;
    int samples_seen;
    int idle_cycles;
    int words_sent;
    int cfg_writes;
    bit calm;
    bit hold_req;
    bit hold_done;

    audio_slot_select_decimator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    assd_stream_checker scoreboard (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding),
        .o_samples_seen  (samples_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || i_cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("no transaction for %0d cycles, %0d samples outstanding",
                     idle_cycles, outstanding);
            $display("audio_slot_select_decimator_core_tb failed");
            $finish;
        end
    end

    // sample sink: random ready gaps, one long hold-off on request
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
                i_m_axis_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IX_W-1:0] index,
                             input logic [CFG_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        cfg_writes++;
    endtask

    task automatic send_word(input logic [WORD_W-1:0] word);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    // stop offering, wait for every predicted sample, then let the core settle
    task automatic quiesce();
        i_s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [BLK_W-1:0]    blk;
        logic [DET_W-1:0]    det;
        logic [SAMPLE_W-1:0] smp;
        int unsigned         kind;
        int unsigned         count;
        int unsigned         pick;
        int unsigned         mix;
        int unsigned         n;
        int                  goal;
        bit                  live;
        bit                  warm;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = REG_BLOCK_WORDS;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // sample extremes, odd phase wins
        write_reg(REG_BLOCK_WORDS, 13'd4);
        write_reg(REG_DETECT_WORDS, 13'd2);
        send_word(32'h7FFF_0000);
        send_word(32'h8000_FFFF);
        send_word(32'h0001_1234);
        send_word(32'hFFFF_ABCD);
        quiesce();

        // block and window below range, tied sums pick even
        write_reg(REG_BLOCK_WORDS, 13'd1);
        write_reg(REG_DETECT_WORDS, 13'd0);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        quiesce();

        // window above range, clamped to the block
        write_reg(REG_BLOCK_WORDS, 13'd3);
        write_reg(REG_DETECT_WORDS, 13'd127);
        send_word(32'h8001_5555);
        send_word(32'h1000_AAAA);
        send_word(32'h0000_0001);
        quiesce();

        // block above range
        write_reg(REG_BLOCK_WORDS, 13'h1FFF);
        write_reg(REG_DETECT_WORDS, 13'd2);
        send_word(32'h0002_0000);
        send_word(32'hC000_0000);
        send_word(32'h1234_5678);
        send_word(32'h8000_0000);
        send_word(32'h0F0F_F0F0);
        quiesce();

        // block shortened below the current position
        write_reg(REG_BLOCK_WORDS, 13'd4);
        send_word(32'h0100_0000);
        send_word(32'h0100_0000);
        send_word(32'h7FFF_7FFF);
        send_word(32'h0000_8000);
        quiesce();

        // window lowered mid-detection: block stays silent
        write_reg(REG_BLOCK_WORDS, 13'd8);
        write_reg(REG_DETECT_WORDS, 13'd6);
        send_word(32'h4000_0000);
        send_word(32'h0040_0000);
        send_word(32'hBFFF_0000);
        quiesce();
        write_reg(REG_DETECT_WORDS, 13'd2);
        send_word(32'h1111_1111);
        send_word(32'h2222_2222);
        send_word(32'h3333_3333);
        send_word(32'h4444_4444);
        send_word(32'h5555_5555);
        quiesce();

        goal = words_sent + RANDOM_WORDS;
        warm = 1'b1;
        while (words_sent < goal) begin
            calm = (goal - words_sent <= CALM_WORDS);
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    blk = BLK_W'($urandom_range(0, 1));
                    det = DET_W'($urandom_range(0, 127));
                end
                1: begin
                    blk = $urandom_range(0, 1) ? 13'h1FFF : BLK_W'($urandom_range(MAX_BLOCK, 8191));
                    det = DET_W'($urandom_range(1, MAX_DETECT));
                end
                2: begin
                    blk = BLK_W'($urandom_range(64, 130));
                    det = $urandom_range(0, 1) ? 7'd127 : 7'd64;
                end
                default: begin
                    blk = BLK_W'($urandom_range(2, 40));
                    det = DET_W'($urandom_range(1, 32'(blk)));
                end
            endcase
            count = $urandom_range(6, 50);
            pick  = $urandom_range(1, 3);
            if (warm) begin
                // one whole block with the full window fills every held entry
                // before any mid-block register change; the sink stalls here
                blk      = BLK_W'($urandom_range(64, 100));
                det      = 7'd64;
                count    = 32'(blk);
                pick     = 3;
                hold_req = 1'b1;
                warm     = 1'b0;
            end
            if (pick[0]) write_reg(REG_BLOCK_WORDS, blk);
            if (pick[1]) write_reg(REG_DETECT_WORDS, CFG_W'(det));
            live = $urandom_range(0, 1);
            for (n = 0; n < count; n++) begin
                mix = $urandom_range(0, 9);
                if (mix == 0) smp = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                else if (mix < 4 || n[0] == live) smp = SAMPLE_W'($urandom);
                else smp = SAMPLE_W'($urandom_range(0, 8) - 4);
                send_word({smp, SAMPLE_W'($urandom)});
            end
            quiesce();
        end

        $display("%0d capture words over %0d register writes, %0d samples compared,",
                 words_sent, cfg_writes, samples_seen);
        $display("including corner blocks and a %0d-cycle output stall", HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("audio_slot_select_decimator_core_tb passed");
        end else begin
            $display("audio_slot_select_decimator_core_tb failed");
        end
        $finish;
    end

endmodule
